// File: rtl/core/sst_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the sorted slot table
package sst_pkg;

  localparam int SLOTS  = 64;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W  = SLOT_W + 1;
  localparam int KEY_W  = 16;

  // command codes, code 3 is unused
  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_READ   = 2'd2
  } cmd_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_LINK,
    ST_ADD_SCAN,
    ST_ADD_PUT,
    ST_RM_SCAN,
    ST_RM_END,
    ST_RD_GET,
    ST_FINISH
  } state_e;

  // request payload
  typedef struct packed {
    logic [1:0]              cmd;
    logic signed [KEY_W-1:0] depth_key;
    logic [SLOT_W-1:0]       slot_sel;
    logic [SLOT_W-1:0]       rank_sel;
  } req_t;

  // response payload
  typedef struct packed {
    logic                    ok;
    logic [SLOT_W-1:0]       slot_out;
    logic [CNT_W-1:0]        change_rank;
    logic signed [KEY_W-1:0] key_out;
    logic [CNT_W-1:0]        entry_count;
  } rsp_t;

  // one entry of the sorted table
  typedef struct packed {
    logic [SLOT_W-1:0]       slot;
    logic signed [KEY_W-1:0] key;
  } entry_t;

endpackage

// File: rtl/core/sorted_slot_table.sv
`timescale 1ns / 1ps
// slot pool with lifo free list and key-sorted entry table
//
//   channel   direction  payload  handshake
//   in        request    req_t    in_valid_i / in_stall_o
//   out       response   rsp_t    out_valid_o / out_stall_i
//
// the walk over the sorted table moves one entry per cycle through its
// single read port and single write port.
// reset needs no clearing pass: per-slot valid bits give the initial chain.
// one request is in work at a time; a new one is taken while the previous
// response still waits on a stalled output.
module sorted_slot_table (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  sst_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output sst_pkg::rsp_t out_rsp_o
);
  import sst_pkg::*;

  // control state
  state_e            state_q, state_d;
  logic [CNT_W-1:0]  free_head_q, free_head_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [SLOTS-1:0]  link_vld_q, link_vld_d;
  logic              more_q, more_d;
  logic              found_q, found_d;
  logic              out_vld_q, out_vld_d;
  logic              rd_vld_q;

  // payload state
  logic [SLOT_W-1:0]       slot_q, slot_d;
  logic signed [KEY_W-1:0] key_q, key_d;
  logic [SLOT_W-1:0]       pos_q, pos_d;
  logic [CNT_W-1:0]        scan_q, scan_d;
  logic [SLOT_W-1:0]       rd_idx_q;
  rsp_t                    res_q, res_d;
  rsp_t                    out_q, out_d;

  // memories
  entry_t           tbl_mem [SLOTS];
  entry_t           rd_data_q;
  logic [CNT_W-1:0] link_mem [SLOTS];
  logic [CNT_W-1:0] link_rd_q;

  // memory ports
  logic              tbl_we, tbl_re, link_we;
  logic [SLOT_W-1:0] tbl_wa, tbl_ra;
  entry_t            tbl_wd;

  // decoded conditions
  logic in_acc, out_free, pool_ok, rank_ok, last_cmp, add_stop;

  assign in_acc   = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_vld_q || !out_stall_i;
  assign pool_ok  = (free_head_q < CNT_W'(SLOTS)) && (count_q < CNT_W'(SLOTS));
  assign rank_ok  = {1'b0, in_req_i.rank_sel} < count_q;
  assign last_cmp = rd_vld_q && ({1'b0, rd_idx_q} == (count_q - CNT_W'(1)));
  assign add_stop = rd_vld_q && (rd_data_q.key <= key_q);

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_vld_q;
  assign out_rsp_o   = out_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (in_req_i.cmd)
            CMD_ADD:    state_d = pool_ok ? ST_ADD_LINK : ST_FINISH;
            CMD_REMOVE: state_d = (count_q == '0) ? ST_RM_END : ST_RM_SCAN;
            CMD_READ:   state_d = rank_ok ? ST_RD_GET : ST_FINISH;
            default:    state_d = ST_FINISH;
          endcase
        end
      end
      ST_ADD_LINK: state_d = (count_q == '0) ? ST_ADD_PUT : ST_ADD_SCAN;
      ST_ADD_SCAN: begin
        if (add_stop || (rd_vld_q && rd_idx_q == '0)) state_d = ST_ADD_PUT;
      end
      ST_ADD_PUT:  state_d = ST_FINISH;
      ST_RM_SCAN: begin
        if (last_cmp) state_d = ST_RM_END;
      end
      ST_RM_END:   state_d = ST_FINISH;
      ST_RD_GET:   state_d = ST_FINISH;
      ST_FINISH: begin
        if (out_free) state_d = ST_IDLE;
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    free_head_d = free_head_q;
    count_d     = count_q;
    link_vld_d  = link_vld_q;
    more_d      = more_q;
    found_d     = found_q;
    slot_d      = slot_q;
    key_d       = key_q;
    pos_d       = pos_q;
    scan_d      = scan_q;
    res_d       = res_q;
    out_d       = out_q;
    out_vld_d   = out_vld_q && out_stall_i;
    tbl_we      = 1'b0;
    tbl_wa      = '0;
    tbl_wd      = rd_data_q;
    tbl_re      = 1'b0;
    tbl_ra      = '0;
    link_we     = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          res_d   = '0;
          key_d   = in_req_i.depth_key;
          pos_d   = '0;
          found_d = 1'b0;
          unique case (in_req_i.cmd)
            CMD_ADD: begin
              slot_d = free_head_q[SLOT_W-1:0];
              scan_d = count_q - CNT_W'(1);
              more_d = 1'b1;
            end
            CMD_REMOVE: begin
              slot_d = in_req_i.slot_sel;
              scan_d = '0;
              more_d = (count_q != '0);
            end
            CMD_READ: begin
              tbl_re = rank_ok;
              tbl_ra = in_req_i.rank_sel;
            end
            default: begin
              more_d = 1'b0;
            end
          endcase
        end
      end

      // pop the free list head
      ST_ADD_LINK: begin
        free_head_d = link_vld_q[slot_q] ? link_rd_q : (CNT_W'(slot_q) + CNT_W'(1));
      end

      // walk down from the top, moving larger keys up by one
      ST_ADD_SCAN: begin
        if (more_q) begin
          tbl_re = 1'b1;
          tbl_ra = scan_q[SLOT_W-1:0];
          scan_d = scan_q - CNT_W'(1);
          more_d = (scan_q != '0);
        end
        if (rd_vld_q) begin
          if (add_stop) begin
            pos_d = rd_idx_q + SLOT_W'(1);
          end else begin
            tbl_we = 1'b1;
            tbl_wa = rd_idx_q + SLOT_W'(1);
            tbl_wd = rd_data_q;
            pos_d  = rd_idx_q;
          end
        end
      end

      ST_ADD_PUT: begin
        tbl_we            = 1'b1;
        tbl_wa            = pos_q;
        tbl_wd            = '{slot: slot_q, key: key_q};
        count_d           = count_q + CNT_W'(1);
        res_d.ok          = 1'b1;
        res_d.slot_out    = slot_q;
        res_d.change_rank = CNT_W'(pos_q);
      end

      // walk up from the bottom, closing the gap once the slot is found
      ST_RM_SCAN: begin
        if (more_q) begin
          tbl_re = 1'b1;
          tbl_ra = scan_q[SLOT_W-1:0];
          scan_d = scan_q + CNT_W'(1);
          more_d = (scan_q + CNT_W'(1)) < count_q;
        end
        if (rd_vld_q) begin
          if (found_q) begin
            tbl_we = 1'b1;
            tbl_wa = rd_idx_q - SLOT_W'(1);
            tbl_wd = rd_data_q;
          end else if (rd_data_q.slot == slot_q) begin
            found_d = 1'b1;
            pos_d   = rd_idx_q;
          end
        end
      end

      // push the slot back on the free list
      ST_RM_END: begin
        if (found_q) begin
          count_d            = count_q - CNT_W'(1);
          link_we            = 1'b1;
          link_vld_d[slot_q] = 1'b1;
          free_head_d        = CNT_W'(slot_q);
          res_d.ok           = 1'b1;
          res_d.change_rank  = CNT_W'(pos_q);
        end
      end

      ST_RD_GET: begin
        res_d.ok       = 1'b1;
        res_d.slot_out = rd_data_q.slot;
        res_d.key_out  = rd_data_q.key;
      end

      ST_FINISH: begin
        if (out_free) begin
          out_d             = res_q;
          out_d.entry_count = count_q;
          out_vld_d         = 1'b1;
        end
      end

      default: begin
        more_d = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      free_head_q <= '0;
      count_q     <= '0;
      link_vld_q  <= '0;
      more_q      <= 1'b0;
      found_q     <= 1'b0;
      out_vld_q   <= 1'b0;
      rd_vld_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      free_head_q <= free_head_d;
      count_q     <= count_d;
      link_vld_q  <= link_vld_d;
      more_q      <= more_d;
      found_q     <= found_d;
      out_vld_q   <= out_vld_d;
      rd_vld_q    <= tbl_re;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    slot_q   <= slot_d;
    key_q    <= key_d;
    pos_q    <= pos_d;
    scan_q   <= scan_d;
    res_q    <= res_d;
    out_q    <= out_d;
    rd_idx_q <= tbl_ra;
  end

  // sorted entry table
  always_ff @(posedge clk_i) begin
    if (tbl_we) tbl_mem[tbl_wa] <= tbl_wd;
    if (tbl_re) rd_data_q <= tbl_mem[tbl_ra];
  end

  // free list links, read at the current head
  always_ff @(posedge clk_i) begin
    if (link_we) link_mem[slot_q] <= free_head_q;
    link_rd_q <= link_mem[free_head_q[SLOT_W-1:0]];
  end

endmodule

// File: rtl/core/sst_checker.sv
`timescale 1ns / 1ps
// port-level checks for the sorted slot table and their binding
module sst_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input sst_pkg::rsp_t out_rsp_o
);
  import sst_pkg::*;

  // a stalled response stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("response dropped while stalled");

  // a stalled response holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_rsp_o))
    else $error("response changed while stalled");

  // a failed request reports no slot, key or rank
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_rsp_o.ok |->
      out_rsp_o.slot_out == '0 && out_rsp_o.key_out == '0 &&
      out_rsp_o.change_rank == '0)
    else $error("failed request carries data");

  // a change rank never lies beyond the resulting count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.ok |-> out_rsp_o.change_rank <= out_rsp_o.entry_count)
    else $error("change rank beyond entry count");

  // the count never exceeds the pool
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_rsp_o.entry_count <= CNT_W'(SLOTS))
    else $error("entry count beyond pool size");

endmodule

bind sorted_slot_table sst_checker u_sst_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_rsp_o   (out_rsp_o)
);

// File: dv/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for the sorted slot table
module testbench;
  import sst_pkg::*;

  localparam logic [1:0]              CMD_UNUSED     = 2'd3;
  localparam logic signed [KEY_W-1:0] KEY_MIN        = 16'sh8000;
  localparam logic signed [KEY_W-1:0] KEY_MAX        = 16'sh7fff;
  localparam int                      HOLD_CYCLES    = 300;
  localparam int                      WATCHDOG_LIMIT = 4000;
  localparam int                      TAIL_CYCLES    = 100;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic out_stall_i = 1'b0;
  req_t in_req_i    = '0;
  logic in_stall_o;
  logic out_valid_o;
  rsp_t out_rsp_o;

  // shadow of the pool and the sorted table
  logic [CNT_W-1:0]        pool_link [SLOTS];
  logic [CNT_W-1:0]        pool_head;
  logic [SLOT_W-1:0]       order_slot [SLOTS];
  logic signed [KEY_W-1:0] order_key [SLOTS];
  int                      order_cnt;

  rsp_t        rsp_pending [$];
  int unsigned errs       = 0;
  int unsigned quiet      = 0;
  bit          in_calm    = 1'b0;
  bit          out_calm   = 1'b0;
  int unsigned hold_ask   = 0;
  int unsigned hold_taken = 0;
  int unsigned stall_left = 0;

  sorted_slot_table DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // mostly no gap, some short ones, a few long ones
  function automatic int unsigned pick_gap(input bit calm);
    int unsigned sel;
    if (calm) return 0;
    sel = $urandom_range(0, 19);
    if (sel < 12) return 0;
    if (sel < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  // keys lean on the extremes and on a few small values so equal keys show up
  function automatic logic signed [KEY_W-1:0] pick_key();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return KEY_MIN;
    if (sel == 1) return KEY_MAX;
    if (sel < 5) return KEY_W'(int'($urandom_range(0, 6)) - 3);
    return KEY_W'($urandom());
  endfunction

  function automatic req_t make_req(input logic [1:0] cmd, input logic signed [KEY_W-1:0] key,
                                    input int unsigned sel, input int unsigned rank);
    req_t r;
    r.cmd       = cmd;
    r.depth_key = key;
    r.slot_sel  = SLOT_W'(sel);
    r.rank_sel  = SLOT_W'(rank);
    return r;
  endfunction

  // pool back to its reset chain, table empty
  function automatic void clear_table();
    for (int i = 0; i < SLOTS; i++) begin
      pool_link[i]  = CNT_W'(i + 1);
      order_slot[i] = '0;
      order_key[i]  = '0;
    end
    pool_head = '0;
    order_cnt = 0;
  endfunction

  // apply one request to the shadow and return its response
  function automatic rsp_t table_step(input req_t r);
    rsp_t              o;
    int                pos;
    logic [SLOT_W-1:0] s;
    o   = '0;
    pos = 0;
    case (r.cmd)
      CMD_ADD: begin
        if (pool_head < SLOTS && order_cnt < SLOTS) begin
          s         = pool_head[SLOT_W-1:0];
          pool_head = pool_link[s];
          // insert after every equal key
          while (pos < order_cnt && $signed(order_key[pos]) <= $signed(r.depth_key)) pos++;
          for (int i = order_cnt; i > pos; i--) begin
            order_slot[i] = order_slot[i-1];
            order_key[i]  = order_key[i-1];
          end
          order_slot[pos] = s;
          order_key[pos]  = r.depth_key;
          order_cnt++;
          o.ok          = 1'b1;
          o.slot_out    = s;
          o.change_rank = CNT_W'(pos);
        end
      end
      CMD_REMOVE: begin
        while (pos < order_cnt && order_slot[pos] != r.slot_sel) pos++;
        if (pos < order_cnt) begin
          for (int i = pos; i + 1 < order_cnt; i++) begin
            order_slot[i] = order_slot[i+1];
            order_key[i]  = order_key[i+1];
          end
          order_cnt--;
          pool_link[r.slot_sel] = pool_head;
          pool_head             = CNT_W'(r.slot_sel);
          o.ok                  = 1'b1;
          o.change_rank         = CNT_W'(pos);
        end
      end
      CMD_READ: begin
        if (r.rank_sel < order_cnt) begin
          o.ok       = 1'b1;
          o.slot_out = order_slot[r.rank_sel];
          o.key_out  = order_key[r.rank_sel];
        end
      end
      default: ;
    endcase
    o.entry_count = CNT_W'(order_cnt);
    return o;
  endfunction

  // random request, weighted by how full the table looks
  function automatic req_t make_mixed_req();
    req_t        r;
    int unsigned pick;
    int unsigned add_w;
    r      = make_req(CMD_UNUSED, pick_key(), $urandom(), $urandom());
    pick   = $urandom_range(0, 99);
    add_w  = (order_cnt < 8) ? 55 : (order_cnt > 52) ? 20 : 35;
    if (pick < add_w) begin
      r.cmd = CMD_ADD;
    end else if (pick < 70) begin
      r.cmd = CMD_REMOVE;
      if (order_cnt != 0 && $urandom_range(0, 4) != 0)
        r.slot_sel = order_slot[$urandom_range(0, order_cnt - 1)];
    end else if (pick < 95) begin
      r.cmd = CMD_READ;
      if (order_cnt != 0 && $urandom_range(0, 3) != 0)
        r.rank_sel = SLOT_W'($urandom_range(0, order_cnt - 1));
    end
    return r;
  endfunction

  // receiver: random stall, or a long hold when the test asks for one
  always @(posedge clk_i) begin
    if (hold_ask != hold_taken) begin
      hold_taken = hold_ask;
      stall_left = HOLD_CYCLES;
    end
    if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
      stall_left = pick_gap(out_calm);
    end
  end

  // predict on each accepted request, check each accepted response, watchdog
  always @(posedge clk_i) begin : check_rsp
    rsp_t want;
    bit   moved;
    moved = 1'b0;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      rsp_pending.insert(rsp_pending.size(), table_step(in_req_i));
      moved = 1'b1;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      moved = 1'b1;
      if (rsp_pending.size() == 0) begin
        $error("response with no request waiting");
        errs++;
      end else begin
        want = rsp_pending.pop_front();
        if (out_rsp_o.ok !== want.ok) begin
          $error("ok: expected %0d, got %0d", want.ok, out_rsp_o.ok);
          errs++;
        end
        if (out_rsp_o.slot_out !== want.slot_out) begin
          $error("slot_out: expected %0d, got %0d", want.slot_out, out_rsp_o.slot_out);
          errs++;
        end
        if (out_rsp_o.change_rank !== want.change_rank) begin
          $error("change_rank: expected %0d, got %0d", want.change_rank, out_rsp_o.change_rank);
          errs++;
        end
        if (out_rsp_o.key_out !== want.key_out) begin
          $error("key_out: expected %0d, got %0d", want.key_out, out_rsp_o.key_out);
          errs++;
        end
        if (out_rsp_o.entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count, out_rsp_o.entry_count);
          errs++;
        end
      end
    end
    if (moved) begin
      quiet = 0;
    end else if (++quiet >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // offer one request, with a random gap ahead of it
  task automatic send_req(input req_t r);
    int unsigned gap;
    gap = pick_gap(in_calm);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_req_i   <= r;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // stop offering and change idling on both sides
  task automatic set_idling(input bit calm_in, input bit calm_out);
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    in_calm  = calm_in;
    out_calm = calm_out;
    @(posedge clk_i);
  endtask

  // stop offering until every response is back
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (rsp_pending.size() != 0) @(posedge clk_i);
  endtask

  // empty table, key extremes, equal keys, misses and the unused code
  task automatic test_directed();
    send_req(make_req(CMD_READ, 0, 0, 0));
    send_req(make_req(CMD_REMOVE, 0, 0, 0));
    send_req(make_req(CMD_UNUSED, 0, 0, 0));
    send_req(make_req(CMD_ADD, KEY_MAX, 0, 0));
    send_req(make_req(CMD_ADD, KEY_MIN, 0, 0));
    send_req(make_req(CMD_ADD, 0, 0, 0));
    send_req(make_req(CMD_ADD, 0, 0, 0));
    send_req(make_req(CMD_ADD, -1, 0, 0));
    send_req(make_req(CMD_ADD, 16'sh0100, 0, 0));
    for (int i = 0; i < 6; i++) send_req(make_req(CMD_READ, 0, 0, i));
    send_req(make_req(CMD_READ, 0, 0, 6));
    send_req(make_req(CMD_READ, 0, 0, SLOTS - 1));
    send_req(make_req(CMD_REMOVE, 0, SLOTS - 1, 0));
    // middle entry out, then its slot comes straight back
    send_req(make_req(CMD_REMOVE, 0, 2, 0));
    send_req(make_req(CMD_ADD, 0, 0, 0));
    send_req(make_req(CMD_REMOVE, 0, 0, 0));
    send_req(make_req(CMD_REMOVE, 0, 1, 0));
    send_req(make_req(CMD_UNUSED, KEY_MIN | KEY_MAX, SLOTS - 1, SLOTS - 1));
  endtask

  // run the pool dry, add past full, then hand every slot back
  task automatic test_fill_pool();
    int unsigned order [SLOTS];
    int unsigned j;
    int unsigned t;
    for (int i = 0; i < 70; i++) send_req(make_req(CMD_ADD, pick_key(), $urandom(), $urandom()));
    send_req(make_req(CMD_READ, 0, 0, SLOTS - 1));
    send_req(make_req(CMD_READ, 0, 0, 0));
    for (int i = 0; i < SLOTS; i++) order[i] = i;
    for (int i = SLOTS - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      t        = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (int i = 0; i < SLOTS; i++)
      send_req(make_req(CMD_REMOVE, pick_key(), order[i], $urandom()));
  endtask

  // output held off for a long stretch while requests keep coming
  task automatic test_backpressure();
    set_idling(1'b1, 1'b1);
    @(negedge clk_i);
    hold_ask++;
    @(posedge clk_i);
    for (int i = 0; i < 12; i++) send_req(make_mixed_req());
    set_idling(1'b0, 1'b0);
  endtask

  // random mix, with idling changed every few dozen requests
  task automatic test_random_mix();
    for (int i = 0; i < 240; i++) begin
      if (i % 60 == 0) set_idling($urandom_range(0, 2) == 0, $urandom_range(0, 2) == 0);
      send_req(make_mixed_req());
    end
    set_idling(1'b0, 1'b0);
  endtask

  initial begin
    clear_table();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    drain();
    test_fill_pool();
    drain();
    test_backpressure();
    drain();
    test_random_mix();
    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (errs == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
